// ===== sv/euve_pkg.sv =====
// shared constants, codes and control types for the encoder unwrap velocity estimator
package euve_pkg;

  // field and state widths
  localparam int ANGLE_BITS = 14;
  localparam int ACCUM_BITS = 32;
  localparam int PP_W       = 7;
  localparam int RATE_W     = 16;
  localparam int ALPHA_W    = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int ELEC_W     = 38;
  localparam int UNW_W      = 32;
  localparam int VEL_BITS   = 46;
  localparam int FRAC_BITS  = 16;
  localparam int FVEL_W     = VEL_BITS - FRAC_BITS;

  // datapath widths
  localparam int RAW_W  = ANGLE_BITS + RATE_W + 1;
  localparam int DIFF_W = RAW_W + FRAC_BITS + 1;
  localparam int LO_W   = DIFF_W / 2;
  localparam int HI_W   = DIFF_W - LO_W;
  localparam int PLO_W  = ALPHA_W + LO_W;
  localparam int PHI_W  = ALPHA_W + 1 + HI_W;

  // limits and reset values
  localparam int PP_MAX      = 64;
  localparam int ALPHA_ONE   = 65536;
  localparam int PP_RESET    = 7;
  localparam int RATE_RESET  = 1000;
  localparam int ALPHA_RESET = 6554;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PP_COUNT     = 2'd0,
    CFG_SAMPLE_RATE  = 2'd1,
    CFG_FILTER_ALPHA = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIFF,
    ST_PROD,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic load_in;
    logic do_diff;
    logic do_prod;
    logic do_upd;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } ctl_stat_t;

endpackage

// ===== sv/euve_if.sv =====
// channel interfaces: angle input, result output and register write
interface euve_in_if;
  import euve_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] angle_sample;
  modport source (output valid, angle_sample, input ready);
  modport sink   (input valid, angle_sample, output ready);
endinterface

interface euve_out_if;
  import euve_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ELEC_W-1:0] electrical_angle;
  logic signed [FVEL_W-1:0] filtered_velocity;
  logic signed [UNW_W-1:0]  unwrapped_angle;
  modport source (output valid, electrical_angle, filtered_velocity, unwrapped_angle,
                  input ready);
  modport sink   (input valid, electrical_angle, filtered_velocity, unwrapped_angle,
                  output ready);
endinterface

interface euve_cfg_if;
  import euve_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/encoder_unwrap_velocity_estimator.sv =====
// top level: encoder angle unwrap with low-pass velocity estimate
//
// in_chan carries one 14-bit mechanical angle word per transfer (valid/ready).
// out_chan returns one word per input: electrical angle (38 bits), filtered
// velocity in counts per second (30 bits) and the unwrapped multi-turn angle.
// cfg_chan writes pole pairs (index 0), sample rate (1) and Q16 alpha (2);
// it is always ready; the user must write it only while the block is idle,
// which the block itself does not enforce. An item goes through these steps
// in order: accept with unwrap and rate multiply, difference against the
// filter state, two partial alpha products, filter update into the output
// register. One item runs at a time, with no new input taken before the last
// has updated, as each update needs the filter state the previous one left.
// The output register lets the next input be accepted while a result waits;
// with the receiver stalled, the following item holds in its update step.
// Synchronous reset clears angle, accumulator and filter state, sets pole
// pairs 7, sample rate 1000 and alpha 6554, and empties the output register.
module encoder_unwrap_velocity_estimator (
  input  logic       clk,
  input  logic       rst_n,
  euve_in_if.sink    in_chan,
  euve_out_if.source out_chan,
  euve_cfg_if.sink   cfg_chan
);
  import euve_pkg::*;

  ctl_cmd_t  ctl_cmd;
  ctl_stat_t ctl_stat;
  logic      out_free;

  assign ctl_stat.in_valid = in_chan.valid;
  assign ctl_stat.out_free = out_free;
  assign in_chan.ready     = ctl_cmd.in_ready;

  euve_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (ctl_stat),
    .cmd   (ctl_cmd)
  );

  euve_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (ctl_cmd),
    .angle_sample (in_chan.angle_sample),
    .out_free     (out_free),
    .out_chan     (out_chan),
    .cfg_chan     (cfg_chan)
  );

  // one item in flight: no second word right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input accepted while an item is in flight");

  // an update never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.do_upd |-> (!out_chan.valid || out_chan.ready))
    else $error("result register overwritten");

  // an update always presents a result next cycle
  a_upd_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.do_upd |=> out_chan.valid)
    else $error("update did not present a result");

  // each input word reaches its update step, or waits there on a stalled receiver
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |-> ##3 ctl_cmd.do_upd || !out_free)
    else $error("update step not reached on schedule");

endmodule

// ===== sv/euve_ctrl.sv =====
// sequencer: one item at a time through diff, product and update steps
module euve_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  euve_pkg::ctl_stat_t stat,
  output euve_pkg::ctl_cmd_t  cmd
);
  import euve_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (stat.in_valid) state_nxt = ST_DIFF;
      end
      ST_DIFF: state_nxt = ST_PROD;
      ST_PROD: state_nxt = ST_UPD;
      ST_UPD: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.load_in  = stat.in_valid;
      end
      ST_DIFF: cmd.do_diff = 1'b1;
      ST_PROD: cmd.do_prod = 1'b1;
      ST_UPD:  cmd.do_upd  = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== sv/euve_dp.sv =====
// datapath: registers, unwrap, velocity scaling, low-pass filter and result register
module euve_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  euve_pkg::ctl_cmd_t              cmd,
  input  logic [euve_pkg::ANGLE_BITS-1:0] angle_sample,
  output logic                            out_free,
  euve_out_if.source                      out_chan,
  euve_cfg_if.sink                        cfg_chan
);
  import euve_pkg::*;

  // configuration
  logic [PP_W-1:0]    pp_r;
  logic [RATE_W-1:0]  rate_r;
  logic [ALPHA_W-1:0] alpha_r;

  // item state
  logic [ANGLE_BITS-1:0] last_r;
  logic [ACCUM_BITS-1:0] acc_r;
  logic [ACCUM_BITS-1:0] acc_nxt;
  logic [VEL_BITS-1:0]   vel_r;
  logic [VEL_BITS-1:0]   vel_nxt;

  // working registers
  logic signed [RAW_W-1:0]  raw_r;
  logic signed [RAW_W-1:0]  raw_nxt;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [DIFF_W-1:0] diff_nxt;
  logic signed [ELEC_W-1:0] elec_r;
  logic signed [ELEC_W-1:0] elec_nxt;
  logic [PLO_W-1:0]         plo_r;
  logic [PLO_W-1:0]         plo_nxt;
  logic signed [PHI_W-1:0]  phi_r;
  logic signed [PHI_W-1:0]  phi_nxt;

  // result register
  logic                     ov_r;
  logic                     ov_nxt;
  logic signed [ELEC_W-1:0] oelec_r;
  logic signed [FVEL_W-1:0] ofvel_r;
  logic signed [UNW_W-1:0]  ounw_r;

  logic signed [ANGLE_BITS-1:0]       step;
  logic signed [RATE_W:0]             rate_s;
  logic [PP_W-1:0]                    pp_eff;
  logic signed [PP_W:0]               pp_s;
  logic [ALPHA_W-1:0]                 alpha_eff;
  logic signed [ALPHA_W:0]            alpha_s;
  logic signed [ELEC_W-1:0]           acc_ext;
  logic signed [RAW_W+FRAC_BITS-1:0]  raw_q16;
  logic [LO_W-1:0]                    diff_lo;
  logic signed [HI_W-1:0]             diff_hi;
  logic [VEL_BITS-1:0]                hi_term;
  logic [VEL_BITS-1:0]                lo_term;

  // step modulo one turn, half turn reads negative
  assign step    = angle_sample - last_r;
  assign rate_s  = signed'({1'b0, rate_r});
  assign raw_nxt = RAW_W'(step) * RAW_W'(rate_s);
  assign acc_nxt = acc_r + ACCUM_BITS'(step);

  always_comb begin
    if (pp_r == '0) begin
      pp_eff = PP_W'(1);
    end else if (pp_r > PP_W'(PP_MAX)) begin
      pp_eff = PP_W'(PP_MAX);
    end else begin
      pp_eff = pp_r;
    end
  end

  always_comb begin
    if (alpha_r > ALPHA_W'(ALPHA_ONE)) begin
      alpha_eff = ALPHA_W'(ALPHA_ONE);
    end else begin
      alpha_eff = alpha_r;
    end
  end

  assign pp_s     = signed'({1'b0, pp_eff});
  assign acc_ext  = ELEC_W'(signed'(acc_r));
  assign elec_nxt = acc_ext * ELEC_W'(pp_s);

  assign raw_q16  = {raw_r, {FRAC_BITS{1'b0}}};
  assign diff_nxt = DIFF_W'(raw_q16) - DIFF_W'(signed'(vel_r));

  // alpha times diff in two partial products, low half unsigned
  assign diff_lo = diff_r[LO_W-1:0];
  assign diff_hi = diff_r[DIFF_W-1:LO_W];
  assign alpha_s = signed'({1'b0, alpha_eff});
  assign plo_nxt = PLO_W'(alpha_eff) * PLO_W'(diff_lo);
  assign phi_nxt = PHI_W'(alpha_s) * PHI_W'(diff_hi);

  // floor of the product over 2^16: high part shifts exactly, low part truncates
  assign hi_term = VEL_BITS'({phi_r, {(LO_W-FRAC_BITS){1'b0}}});
  assign lo_term = VEL_BITS'(plo_r[PLO_W-1:FRAC_BITS]);
  assign vel_nxt = vel_r + hi_term + lo_term;

  assign out_free = !ov_r || out_chan.ready;

  always_comb begin
    if (cmd.do_upd) begin
      ov_nxt = 1'b1;
    end else if (out_chan.ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_r    <= PP_W'(PP_RESET);
      rate_r  <= RATE_W'(RATE_RESET);
      alpha_r <= ALPHA_W'(ALPHA_RESET);
      last_r  <= '0;
      acc_r   <= '0;
      vel_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (cfg_chan.valid) begin
        unique case (cfg_chan.index)
          CFG_PP_COUNT:     pp_r    <= cfg_chan.data[PP_W-1:0];
          CFG_SAMPLE_RATE:  rate_r  <= cfg_chan.data[RATE_W-1:0];
          CFG_FILTER_ALPHA: alpha_r <= cfg_chan.data[ALPHA_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load_in) begin
        last_r <= angle_sample;
        acc_r  <= acc_nxt;
      end
      if (cmd.do_upd) begin
        vel_r <= vel_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      raw_r <= raw_nxt;
    end
    if (cmd.do_diff) begin
      diff_r <= diff_nxt;
      elec_r <= elec_nxt;
    end
    if (cmd.do_prod) begin
      plo_r <= plo_nxt;
      phi_r <= phi_nxt;
    end
    if (cmd.do_upd) begin
      oelec_r <= elec_r;
      ofvel_r <= vel_nxt[VEL_BITS-1:FRAC_BITS];
      ounw_r  <= UNW_W'(signed'(acc_r));
    end
  end

  assign cfg_chan.ready             = 1'b1;
  assign out_chan.valid             = ov_r;
  assign out_chan.electrical_angle  = oelec_r;
  assign out_chan.filtered_velocity = ofvel_r;
  assign out_chan.unwrapped_angle   = ounw_r;

endmodule

// ===== tb/sv/euve_motion_checker.sv =====
// checker: predicts the unwrap and velocity results and compares them with the output channel
`timescale 1ns / 100ps

module euve_motion_checker (
  input  logic clk,
  input  logic rst_n,
  euve_in_if   in_chan,
  euve_out_if  out_chan,
  euve_cfg_if  cfg_chan,
  output int   fail_count,
  output int   pending,
  output int   words_checked
);
  import euve_pkg::*;

  typedef struct packed {
    logic signed [ELEC_W-1:0] elec;
    logic signed [FVEL_W-1:0] fvel;
    logic signed [UNW_W-1:0]  unw;
  } motion_t;

  motion_t motion_q[$];

  // shadow registers and filter state
  logic [PP_W-1:0]            pp_count;
  logic [RATE_W-1:0]          rate_hz;
  logic [ALPHA_W-1:0]         alpha_q16;
  logic [ANGLE_BITS-1:0]      prev_angle;
  logic [ACCUM_BITS-1:0]      turns;
  logic signed [VEL_BITS-1:0] vel_q16;

  function automatic motion_t track_motion(input logic [ANGLE_BITS-1:0] angle);
    logic signed [ANGLE_BITS-1:0] step;
    logic signed [ACCUM_BITS-1:0] acc;
    logic signed [79:0]           raw;
    logic signed [79:0]           diff;
    logic signed [79:0]           prod;
    longint                       st;
    longint                       rt;
    longint                       pp;
    longint                       k;
    motion_t                      m;
    // step taken modulo one turn, half turn reads negative
    step = angle - prev_angle;
    st   = step;
    rt   = rate_hz;
    pp   = (pp_count == 0) ? 1 : ((pp_count > PP_MAX) ? PP_MAX : pp_count);
    k    = (alpha_q16 > ALPHA_ONE) ? ALPHA_ONE : alpha_q16;
    prev_angle = angle;
    turns      = turns + st[ACCUM_BITS-1:0];
    raw        = st * rt * 65536;
    diff       = raw - vel_q16;
    prod       = k * diff;
    vel_q16    = VEL_BITS'(vel_q16 + (prod >>> FRAC_BITS));
    acc        = turns;
    m.elec     = ELEC_W'(acc * pp);
    m.fvel     = FVEL_W'(vel_q16 >>> FRAC_BITS);
    m.unw      = acc;
    return m;
  endfunction

  initial begin
    fail_count    = 0;
    pending       = 0;
    words_checked = 0;
  end

  always @(posedge clk) begin
    motion_t want;
    if (!rst_n) begin
      pp_count   = PP_W'(PP_RESET);
      rate_hz    = RATE_W'(RATE_RESET);
      alpha_q16  = ALPHA_W'(ALPHA_RESET);
      prev_angle = '0;
      turns      = '0;
      vel_q16    = '0;
      motion_q.delete();
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_idx_t'(cfg_chan.index))
          CFG_PP_COUNT:     pp_count  = cfg_chan.data[PP_W-1:0];
          CFG_SAMPLE_RATE:  rate_hz   = cfg_chan.data[RATE_W-1:0];
          CFG_FILTER_ALPHA: alpha_q16 = cfg_chan.data[ALPHA_W-1:0];
          default: ;
        endcase
      end
      if (in_chan.valid && in_chan.ready)
        motion_q.push_back(track_motion(in_chan.angle_sample));
      if (out_chan.valid && out_chan.ready) begin
        if (motion_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          want = motion_q.pop_front();
          words_checked++;
          if (out_chan.electrical_angle !== want.elec) begin
            $error("electrical_angle: expected %0d, got %0d", want.elec,
                   out_chan.electrical_angle);
            fail_count++;
          end
          if (out_chan.filtered_velocity !== want.fvel) begin
            $error("filtered_velocity: expected %0d, got %0d", want.fvel,
                   out_chan.filtered_velocity);
            fail_count++;
          end
          if (out_chan.unwrapped_angle !== want.unw) begin
            $error("unwrapped_angle: expected %0d, got %0d", want.unw,
                   out_chan.unwrapped_angle);
            fail_count++;
          end
        end
      end
    end
    pending = motion_q.size();
  end

endmodule

// ===== tb/sv/tb_encoder_unwrap_velocity_estimator.sv =====
// testbench top: angle stimulus, register settings and verdict for the velocity estimator
`timescale 1ns / 100ps

module tb_encoder_unwrap_velocity_estimator;
  import euve_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 250;
  localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(1 << (ANGLE_BITS - 1));

  logic clk;
  logic rst_n;
  bit   idle_en;
  int   fail_count;
  int   pending;
  int   words_checked;
  int   words_sent;
  int   reg_writes;
  int   settings;
  int unsigned cycle_count;

  euve_in_if  in_chan ();
  euve_out_if out_chan ();
  euve_cfg_if cfg_chan ();

  encoder_unwrap_velocity_estimator u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  euve_motion_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_chan       (in_chan),
    .out_chan      (out_chan),
    .cfg_chan      (cfg_chan),
    .fail_count    (fail_count),
    .pending       (pending),
    .words_checked (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
    $display("Simulation FAILED");
    $finish;
  end

  // receiver stalls in random bursts
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 5) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  task automatic send_angle(input logic [ANGLE_BITS-1:0] angle);
    @(negedge clk);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.angle_sample <= angle;
    do @(posedge clk); while (!in_chan.ready);
    words_sent++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= value;
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
    reg_writes++;
  endtask

  // hold off the sender until every result is back, then let the pipe settle
  task automatic wait_drained();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] pp,
                               input logic [CFG_DATA_W-1:0] rate,
                               input logic [CFG_DATA_W-1:0] alpha);
    wait_drained();
    cfg_write(CFG_PP_COUNT, pp);
    cfg_write(CFG_SAMPLE_RATE, rate);
    cfg_write(CFG_FILTER_ALPHA, alpha);
    settings++;
  endtask

  initial begin
    logic [ANGLE_BITS-1:0] cur_angle;
    logic [CFG_DATA_W-1:0] pp;
    logic [CFG_DATA_W-1:0] rate;
    logic [CFG_DATA_W-1:0] alpha;
    int                    speed;
    int                    span;

    rst_n                = 1'b0;
    idle_en              = 1'b1;
    in_chan.valid        = 1'b0;
    in_chan.angle_sample = '0;
    cfg_chan.valid       = 1'b0;
    cfg_chan.index       = '0;
    cfg_chan.data        = '0;
    words_sent           = 0;
    reg_writes           = 0;
    settings             = 1;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: first word steps from zero, wrap both ways, half turns
    send_angle(0);
    send_angle(16383);
    send_angle(0);
    send_angle(HALF_TURN);
    send_angle(0);
    send_angle(HALF_TURN - 1'b1);
    send_angle(16383);
    send_angle(1);

    // pole pairs zero reads as one, fastest rate, alpha of exactly one
    apply_setting(0, 65535, CFG_DATA_W'(ALPHA_ONE));
    send_angle(HALF_TURN);
    send_angle(0);
    send_angle(HALF_TURN);
    send_angle(16383);

    // pole pairs above the max, rate zero, alpha saturating
    apply_setting(127, 0, 17'h1FFFF);
    send_angle(100);
    send_angle(16000);

    // alpha zero freezes the filter; an unmapped index must change nothing
    apply_setting(CFG_DATA_W'(PP_MAX), 1, 0);
    cfg_write(CFG_UNMAPPED, 17'h1FFFF);
    send_angle(5);
    send_angle(9000);

    apply_setting(1, 65535, 1);
    send_angle(16383);
    send_angle(HALF_TURN);
    send_angle(42);

    cur_angle = 42;
    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0:       pp = CFG_DATA_W'($urandom_range(1, PP_MAX));
        1:       pp = CFG_DATA_W'($urandom_range(0, 127));
        2:       pp = CFG_DATA_W'($urandom());
        default: pp = CFG_DATA_W'((ph % 2) ? PP_MAX : 1);
      endcase
      case ($urandom_range(0, 4))
        0:       rate = 65535;
        1:       rate = CFG_DATA_W'($urandom_range(0, 3));
        2:       rate = CFG_DATA_W'(RATE_RESET);
        default: rate = CFG_DATA_W'($urandom());
      endcase
      case ($urandom_range(0, 5))
        0:       alpha = CFG_DATA_W'(ALPHA_ONE);
        1:       alpha = CFG_DATA_W'($urandom_range(0, 2));
        2:       alpha = CFG_DATA_W'($urandom_range(ALPHA_ONE, 17'h1FFFF));
        default: alpha = CFG_DATA_W'($urandom_range(0, ALPHA_ONE));
      endcase
      apply_setting(pp, rate, alpha);
      if ($urandom_range(0, 2) == 0)
        cfg_write(CFG_UNMAPPED, CFG_DATA_W'($urandom()));
      // the last phase runs with no gaps on either side
      idle_en = (ph != PHASES - 1);
      span    = 1 << $urandom_range(0, ANGLE_BITS - 1);
      speed   = $urandom_range(0, 2 * span) - span;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (ph == 2 && i == PHASE_WORDS / 2)
          wait_drained();
        case ($urandom_range(0, 19))
          0, 1:    cur_angle = ANGLE_BITS'($urandom());
          2:       cur_angle = cur_angle + HALF_TURN;
          3:       cur_angle = $urandom_range(0, 1) ? '0 : '1;
          4: begin
            span  = 1 << $urandom_range(0, ANGLE_BITS - 1);
            speed = $urandom_range(0, 2 * span) - span;
            cur_angle = ANGLE_BITS'(cur_angle + speed);
          end
          default: cur_angle = ANGLE_BITS'(cur_angle + speed + $urandom_range(0, 6) - 3);
        endcase
        send_angle(cur_angle);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("sent %0d angle words with %0d register writes over %0d settings",
             words_sent, reg_writes, settings);
    $display("checked %0d result words, %0d failures", words_checked, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
